>>> sv/itrs_pkg.sv
// Shared types, constants and helpers of the radix string converter.
// No dependencies; imported by the divider, the digit memory and the core.
`default_nettype none

package itrs_pkg;

	localparam int VALUE_W = 32;
	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 8;

	// Radix limits and the one radix that gets a minus sign
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

	// Conversion modes
	localparam logic CMD_SIGNED   = 1'b0;
	localparam logic CMD_UNSIGNED = 1'b1;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ERR   = 8'h00;
	localparam logic [CHAR_W-1:0] TEN        = 8'd10;

	// Divider status toward the sequencer
	typedef struct packed {
		logic              done;
		logic [BASE_W-1:0] rem;
	} div_stat_t;

	// Map a digit value from 0 to 35 onto '0'..'9', 'a'..'z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {2'b00, d};
		if (dw < TEN) begin
			return CHAR_ZERO + dw;
		end
		return CHAR_A + dw - TEN;
	endfunction

endpackage

`default_nettype wire

>>> sv/itrs_divider.sv
// Shared restoring divider: one quotient bit per cycle, small divisor.
// Depends on itrs_pkg for the divisor width and the status struct.
`default_nettype none

module itrs_divider
	import itrs_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [WORD_BITS-1:0] dividend,
	input  wire logic [BASE_W-1:0]    divisor,
	output logic [WORD_BITS-1:0]      quotient,
	output div_stat_t                 stat
);

	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] quo_q;
	logic [BASE_W-1:0]    rem_q;
	logic [BASE_W-1:0]    dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [BASE_W:0]      rem_sh;
	logic [BASE_W:0]      rem_sub;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[WORD_BITS-1]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control: count the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
			rem_q <= fits ? rem_sub[BASE_W-1:0] : rem_sh[BASE_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire

>>> sv/itrs_digit_mem.sv
// Digit store: characters written least significant first, read back in reverse.
// Single write port, single registered read port; depends on itrs_pkg.
`default_nettype none

module itrs_digit_mem
	import itrs_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [CHAR_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [CHAR_W-1:0]             rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rd_data_q;

	// Write a digit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read a digit; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> sv/integer_to_radix_string_core.sv
// Integer to ASCII string converter, radix 2 to 36. One transfer on the input
// channel carries a word, a radix and a mode bit; the output channel then gives
// one transfer per character, most significant digit first, lower-case letters
// above 9, with last set on the final character. Signed mode prints a minus and
// the magnitude only for negative words in radix 10. A radix outside 2..36 gives
// one transfer with error set and character 0. Digits come from one shared
// restoring divider that yields a quotient bit per cycle; readout from the digit
// store then passes each character through a read state and an emit state.
// The input stalls while an item is in flight; it accepts the next item as soon
// as the final character sits in the output register.
// Depends on itrs_pkg, itrs_divider and itrs_digit_mem.
`default_nettype none

module integer_to_radix_string_core
	import itrs_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [BASE_W-1:0]  base,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [CHAR_W-1:0]       out_char,
	output logic                    error,
	output logic                    last
);

	localparam int CNT_W  = $clog2(WORD_BITS + 1);
	localparam int ADDR_W = $clog2(WORD_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_RD,
		S_EMIT,
		S_ERR
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [BASE_W-1:0]    base_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 error_q;
	logic                 last_q;

	logic                 in_acc;
	logic                 slot_free;
	logic                 out_load;
	logic                 base_ok;
	logic                 neg_in;
	logic [WORD_BITS-1:0] mag_in;
	logic [WORD_BITS-1:0] mag_abs;
	logic [CNT_W-1:0]     rd_idx;

	logic                 div_start;
	logic [WORD_BITS-1:0] div_dividend;
	logic [BASE_W-1:0]    div_divisor;
	logic [WORD_BITS-1:0] div_quo;
	div_stat_t            div_stat;

	logic                 mem_we;
	logic [CHAR_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic [CHAR_W-1:0]    mem_rdata;

	// Decode the input item
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = slot_free &&
		((state_q == S_ERR) || (state_q == S_SIGN) || (state_q == S_EMIT));
	assign base_ok   = (base >= BASE_MIN) && (base <= BASE_MAX);
	assign mag_in    = WORD_BITS'({{WORD_BITS{1'b0}}, value});
	assign neg_in    = (cmd == CMD_SIGNED) && (base == BASE_DEC) && mag_in[WORD_BITS-1];
	assign mag_abs   = neg_in ? (~mag_in + WORD_BITS'(1)) : mag_in;
	assign rd_idx    = cnt_q - CNT_W'(1);
	assign mem_wdata = digit_char(div_stat.rem);

	// Drive the divider and the digit store from the sequencer state
	always_comb begin
		div_start    = 1'b0;
		div_dividend = mag_abs;
		div_divisor  = base;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				div_start = in_acc && base_ok;
			end
			S_DIV: begin
				if (div_stat.done) begin
					mem_we = 1'b1;
					if (div_quo != '0) begin
						div_start    = 1'b1;
						div_dividend = div_quo;
						div_divisor  = base_q;
					end
				end
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			default: ;
		endcase
	end

	itrs_divider #(
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	itrs_digit_mem #(
		.DEPTH(WORD_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (rd_idx[ADDR_W-1:0]),
		.rd_data (mem_rdata)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the output once it is transferred and nothing replaces it
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						base_q  <= base;
						neg_q   <= neg_in;
						cnt_q   <= '0;
						state_q <= base_ok ? S_DIV : S_ERR;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CHAR_ERR;
						error_q     <= 1'b1;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (div_quo == '0) begin
							state_q <= neg_q ? S_SIGN : S_RD;
						end
					end
				end
				S_SIGN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CHAR_MINUS;
						error_q     <= 1'b0;
						last_q      <= 1'b0;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					cnt_q   <= rd_idx;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= mem_rdata;
						error_q     <= 1'b0;
						last_q      <= (cnt_q == '0);
						state_q     <= (cnt_q == '0) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign error     = error_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	// An error result is always a single, final, zero character
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && (out_char == CHAR_ERR))
		else $error("error result without last or with a nonzero character");

	// The digit count never exceeds the word width
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WORD_BITS))
		else $error("digit count beyond word width");

	// The divider reports completion only while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider done outside the divide state");

	// A new item starts only after every stored digit has been sent
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> cnt_q == '0)
		else $error("item accepted with digits still pending");
`endif

endmodule

`default_nettype wire

>>> tb/integer_to_radix_string_core_test.sv
// Self-checking bench for integer_to_radix_string_core: drives words, radixes and
// modes, predicts the ASCII characters of each word and checks every output transfer.
// Depends on itrs_pkg and the core with its divider and digit memory.
`default_nettype none

module integer_to_radix_string_core_test;
	import itrs_pkg::*;

	localparam int WORD_BITS   = 32;
	localparam int HOLD_CYCLES = 500;
	localparam int QUIET_LIMIT = 10000;
	localparam int DRAIN_CYCLES = 1200;
	localparam int MAX_REPORTS = 40;

	// One word to convert, as it goes onto the input channel
	typedef struct {
		logic              mode;
		logic [VALUE_W-1:0] word;
		logic [BASE_W-1:0]  radix;
	} word_item_t;

	// One character as it should leave the output channel
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              err;
		logic              is_last;
	} char_rec_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = CMD_SIGNED;
	logic [VALUE_W-1:0] value = '0;
	logic [BASE_W-1:0]  base = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CHAR_W-1:0]  out_char;
	logic               error;
	logic               last;

	word_item_t pending_words[$];
	char_rec_t  expected_chars[$];
	word_item_t next_word;
	char_rec_t  head_char;

	int words_queued = 0;
	int words_taken = 0;
	int chars_checked = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	integer_to_radix_string_core #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.value    (value),
		.base     (base),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.error    (error),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Append the characters that one word should print to the expected store
	function automatic void predict_chars(input logic mode, input logic [VALUE_W-1:0] word,
			input logic [BASE_W-1:0] radix);
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  dig;
		logic [CHAR_W-1:0]  digits[$];
		logic               negative;
		if (radix < BASE_MIN || radix > BASE_MAX) begin
			expected_chars.push_back('{ch: CHAR_ERR, err: 1'b1, is_last: 1'b1});
			return;
		end
		// minus sign only for negative words in radix 10, signed mode
		negative = (mode == CMD_SIGNED) && (radix == BASE_DEC) && word[WORD_BITS-1];
		mag = negative ? (~word + 1'b1) : word;
		do begin
			dig = CHAR_W'(mag % VALUE_W'(radix));
			digits.push_front((dig < TEN) ? CHAR_ZERO + dig : CHAR_A + dig - TEN);
			mag = mag / VALUE_W'(radix);
		end while (mag != 0);
		if (negative)
			expected_chars.push_back('{ch: CHAR_MINUS, err: 1'b0, is_last: 1'b0});
		foreach (digits[i])
			expected_chars.push_back('{ch: digits[i], err: 1'b0,
				is_last: (i == digits.size() - 1)});
	endfunction

	task automatic queue_word(input logic mode, input logic [VALUE_W-1:0] word,
			input logic [BASE_W-1:0] radix);
		pending_words.push_back('{mode: mode, word: word, radix: radix});
		words_queued++;
	endtask

	// Mostly legal radixes with a bias to radix 10, and varied word sizes
	task automatic queue_random_words(input int count);
		logic [VALUE_W-1:0] word;
		logic [BASE_W-1:0]  radix;
		int                 pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 10)
				radix = ($urandom_range(1) != 0) ? BASE_W'($urandom_range(1)) :
					BASE_W'($urandom_range(37, 63));
			else if (pick < 35)
				radix = BASE_DEC;
			else
				radix = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
			pick = $urandom_range(99);
			if (pick < 45)
				word = $urandom;
			else if (pick < 70)
				word = $urandom >> $urandom_range(1, 31);
			else if (pick < 85)
				word = $urandom_range(0, 40);
			else
				word = VALUE_W'(0) - VALUE_W'($urandom_range(1, 1000));
			queue_word(1'($urandom_range(1)), word, radix);
		end
	endtask

	// Hold off the sender until every word is taken and every character is out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_taken != words_queued || expected_chars.size() != 0);
	endtask

	task automatic report(input string field, input logic [CHAR_W-1:0] want,
			input logic [CHAR_W-1:0] got);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		mismatches++;
	endtask

	// Input side: take accepted transfers, offer the next word unless idling
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_chars(cmd, value, base);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					cmd <= next_word.mode;
					value <= next_word.word;
					base <= next_word.radix;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each transfer, stall at random or for a long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: character %h with none expected, expected nothing",
							$time, out_char);
					mismatches++;
				end else begin
					head_char = expected_chars.pop_front();
					if (head_char.ch !== out_char)
						report("out_char", head_char.ch, out_char);
					if (head_char.err !== error)
						report("error", CHAR_W'(head_char.err), CHAR_W'(error));
					if (head_char.is_last !== last)
						report("last", CHAR_W'(head_char.is_last), CHAR_W'(last));
				end
				chars_checked++;
			end
			if (holds_served != holds_asked) begin
				holds_served <= holds_asked;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles often, receiver idles more
		send_idle_pct = 34;
		recv_idle_pct = 71;
		queue_word(CMD_SIGNED, 32'h0000_0000, BASE_DEC);
		queue_word(CMD_UNSIGNED, 32'h0000_0000, BASE_MIN);
		queue_word(CMD_SIGNED, 32'h8000_0000, BASE_DEC);
		queue_word(CMD_SIGNED, 32'h7fff_ffff, BASE_DEC);
		queue_word(CMD_SIGNED, 32'hffff_ffff, BASE_DEC);
		queue_word(CMD_UNSIGNED, 32'hffff_ffff, BASE_DEC);
		queue_word(CMD_UNSIGNED, 32'hffff_ffff, BASE_MIN);
		queue_word(CMD_SIGNED, 32'h8000_0000, BASE_MIN);
		queue_word(CMD_SIGNED, 32'hffff_ffff, 6'd16);
		queue_word(CMD_UNSIGNED, 32'hffff_ffff, BASE_MAX);
		queue_word(CMD_SIGNED, 32'd35, BASE_MAX);
		queue_word(CMD_UNSIGNED, 32'd10, 6'd11);
		queue_word(CMD_SIGNED, 32'd9, BASE_DEC);
		queue_word(CMD_UNSIGNED, 32'h8000_0000, BASE_DEC);
		queue_word(CMD_SIGNED, 32'hffff_ff85, 6'd8);
		queue_word(CMD_UNSIGNED, 32'd12345, 6'd3);
		queue_word(CMD_SIGNED, 32'hdead_beef, BASE_MAX);
		queue_word(CMD_UNSIGNED, 32'h5555_5555, 6'd4);
		queue_word(CMD_SIGNED, 32'haaaa_aaaa, BASE_DEC);
		// radixes out of range
		queue_word(CMD_SIGNED, 32'd0, 6'd0);
		queue_word(CMD_UNSIGNED, 32'd7, 6'd1);
		queue_word(CMD_SIGNED, 32'd100, 6'd37);
		queue_word(CMD_UNSIGNED, 32'hffff_ffff, 6'd63);
		queue_random_words(75);
		wait_drained();

		// Sender idles more, receiver less
		send_idle_pct = 71;
		recv_idle_pct = 34;
		queue_random_words(85);
		wait_drained();

		// No idling; a long output hold backs the block up into its input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holds_asked++;
		queue_random_words(70);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("converted %0d words into %0d checked characters, %0d mismatches",
			words_taken, chars_checked, mismatches);
		$display("covered signed and unsigned modes, radix 0 to 63, three idle mixes, one long hold");
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
sv/itrs_pkg.sv
sv/itrs_divider.sv
sv/itrs_digit_mem.sv
sv/integer_to_radix_string_core.sv
tb/integer_to_radix_string_core_test.sv
